[design/abrc_pkg.sv]
// ----------------------------------------------------------------------------
// Beacon repetition controller package
// Shared types, codes and constants for the controller and its datapath.
// ----------------------------------------------------------------------------
package abrc_pkg;

  // One million parts per million.
  localparam logic [19:0] PPM_ONE = 20'd1000000;
  // Report loss base: one million minus the header part (31+16)*8 and 16*8.
  localparam logic [19:0] RPT_BASE = 20'd999496;

  // Event kinds on the input channel.
  localparam logic [1:0] ACT_ADVERT = 2'd0;
  localparam logic [1:0] ACT_REPORT = 2'd1;
  localparam logic [1:0] ACT_SCAN_END = 2'd2;
  localparam logic [1:0] ACT_MINUTE = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_EPOCH_MINUTES = 2'd0;
  localparam logic [1:0] CFG_GATEWAY_LOSS = 2'd1;
  localparam logic [1:0] CFG_TARGET = 2'd2;

  // Result word, first field in the highest bits.
  typedef struct packed {
    logic        scan_start;
    logic [3:0]  repetitions;
    logic [31:0] heard_estimate;
    logic [3:0]  packet_index;
    logic [31:0] data_index;
    logic [15:0] epoch_number;
    logic [10:0] interval_units;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input word
    logic advert;     // emit an advert payload and step counters
    logic clr_res;    // result without an advert
    logic tick;       // minute tick
    logic scan_init;  // close the scan window
    logic md_rpt;     // start report loss scaling
    logic md_scan;    // start gateway loss scaling
    logic md_sq;      // start failure squaring
    logic rpt_done;   // take report product
    logic p_load;     // take scaled success
    logic sq_done;    // take squared result
    logic set_reps;   // commit repetitions and interval
    logic push;       // move the result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] action;
    logic       scanning;
    logic       md_done;
    logic       p_below;
    logic       n_below_max;
    logic       out_free;
  } ctrl_status_t;

  // Advert interval for a repetition count: rate (1000-5n)/n ms, at least
  // 100 ms, in 0.625 ms units.
  function automatic logic [10:0] interval_for(input logic [3:0] n);
    logic [10:0] r;
    unique case (n)
      4'd1:    r = 11'd1592;
      4'd2:    r = 11'd792;
      4'd3:    r = 11'd524;
      4'd4:    r = 11'd392;
      4'd5:    r = 11'd312;
      4'd6:    r = 11'd257;
      4'd7:    r = 11'd219;
      4'd8:    r = 11'd192;
      4'd9:    r = 11'd169;
      default: r = 11'd160;
    endcase
    return r;
  endfunction

endpackage

[design/abrc_muldiv.sv]
// ----------------------------------------------------------------------------
// Scaled multiplier
// Computes floor(a*b/1000000) in registered steps: the product, a quotient
// estimate from its high half by a reciprocal multiply, the remainder of
// that estimate, and a final correction of at most two.
// ----------------------------------------------------------------------------
module abrc_muldiv (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [19:0] a_i,
  input  logic [19:0] b_i,
  output logic        done_o,
  output logic [19:0] quot_o
);

  // 2^40 / 1000000, floored. Applied to the high half of the product, the
  // estimate never exceeds the true quotient and falls short by at most two.
  localparam logic [20:0] RECIP = 21'd1099511;
  localparam logic [21:0] ONE_M = 22'd1000000;
  localparam logic [21:0] TWO_M = 22'd2000000;

  logic [39:0] prod_q;
  logic [19:0] est_q, quot_q;
  logic [21:0] rem_q;
  logic [2:0]  stage_q;
  logic        done_q;
  logic [39:0] est_full;
  logic [39:0] est_back;
  logic [1:0]  fix;

  // Reciprocal estimate and its back product; the remainder fits 22 bits.
  assign est_full = 40'(prod_q[39:20]) * 40'(RECIP);
  assign est_back = 40'(est_q) * 40'(abrc_pkg::PPM_ONE);

  // Final correction from the remainder.
  always_comb begin
    if (rem_q >= TWO_M) begin
      fix = 2'd2;
    end else if (rem_q >= ONE_M) begin
      fix = 2'd1;
    end else begin
      fix = 2'd0;
    end
  end

  // Stage marker: product, estimate, remainder, then done.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= 3'd0;
      done_q  <= 1'b0;
    end else begin
      stage_q <= {stage_q[1:0], start_i};
      done_q  <= stage_q[2];
    end
  end

  // Arithmetic registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= 40'(a_i) * 40'(b_i);
    end
    if (stage_q[0]) begin
      est_q <= est_full[39:20];
    end
    if (stage_q[1]) begin
      rem_q <= prod_q[21:0] - est_back[21:0];
    end
    if (stage_q[2]) begin
      quot_q <= est_q + {18'd0, fix};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[design/abrc_datapath.sv]
// ----------------------------------------------------------------------------
// Beacon repetition datapath
// Counters, success product, configuration registers, the scaled multiplier
// and the output register.
// ----------------------------------------------------------------------------
module abrc_datapath #(
  parameter int MAX_REPEATS = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [1:0]               action_i,
  input  logic [4:0]               report_length_i,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_addr_i,
  input  logic [19:0]              cfg_data_i,
  input  abrc_pkg::ctrl_cmd_t      cmd_i,
  output abrc_pkg::ctrl_status_t   st_o,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic                     out_advert_o,
  output abrc_pkg::result_t        out_res_o
);

  logic [7:0]  epoch_min_q;
  logic [19:0] loss_q, target_q;
  logic [1:0]  action_q;
  logic [4:0]  len_q;
  logic [10:0] interval_q;
  logic [15:0] epoch_q;
  logic [31:0] data_q, estimate_q, heard_q;
  logic [3:0]  packet_q, repeat_q, n_q;
  logic        pending_q, scanning_q;
  logic [7:0]  minute_q;
  logic [19:0] product_q, p_q;
  logic        res_adv_q, out_valid_q, out_adv_q;
  abrc_pkg::result_t res_q, out_res_q;

  logic        md_start, md_done;
  logic [19:0] md_a, md_b, md_q, loss_clamp, fail;
  logic [3:0]  packet_inc;
  logic [7:0]  minute_inc;
  logic        out_free;

  assign loss_clamp = (loss_q > abrc_pkg::PPM_ONE) ? abrc_pkg::PPM_ONE : loss_q;
  assign fail       = abrc_pkg::PPM_ONE - p_q;
  assign packet_inc = packet_q + 4'd1;
  assign minute_inc = minute_q + 8'd1;
  assign out_free   = !out_valid_q || out_ready_i;

  // Operand selection for the shared scaled multiplier.
  assign md_start = cmd_i.md_rpt || cmd_i.md_scan || cmd_i.md_sq;
  always_comb begin
    md_a = fail;
    md_b = fail;
    if (cmd_i.md_rpt) begin
      md_a = product_q;
      md_b = abrc_pkg::RPT_BASE - {12'd0, len_q, 3'b000};
    end else if (cmd_i.md_scan) begin
      md_a = product_q;
      md_b = abrc_pkg::PPM_ONE - loss_clamp;
    end
  end

  abrc_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .a_i     (md_a),
    .b_i     (md_b),
    .done_o  (md_done),
    .quot_o  (md_q)
  );

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_min_q <= 8'd10;
      loss_q      <= 20'd78800;
      target_q    <= 20'd990000;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        abrc_pkg::CFG_EPOCH_MINUTES: epoch_min_q <= cfg_data_i[7:0];
        abrc_pkg::CFG_GATEWAY_LOSS:  loss_q      <= cfg_data_i;
        abrc_pkg::CFG_TARGET:        target_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input word capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_i;
      len_q    <= report_length_i;
    end
  end

  // Scan-end search registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= 20'd0;
      n_q <= 4'd1;
    end else begin
      if (cmd_i.scan_init) begin
        n_q <= 4'd1;
      end
      if (cmd_i.p_load) begin
        p_q <= md_q;
      end
      if (cmd_i.md_sq) begin
        n_q <= n_q + 4'd1;
      end
      if (cmd_i.sq_done) begin
        p_q <= abrc_pkg::PPM_ONE - md_q;
      end
    end
  end

  // Beacon state and the result being built.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= 11'd1592;
      epoch_q    <= 16'd0;
      data_q     <= 32'd0;
      packet_q   <= 4'd0;
      estimate_q <= 32'd0;
      repeat_q   <= 4'd1;
      pending_q  <= 1'b0;
      minute_q   <= 8'd0;
      scanning_q <= 1'b0;
      heard_q    <= 32'd0;
      product_q  <= abrc_pkg::PPM_ONE;
      res_adv_q  <= 1'b0;
      res_q      <= '0;
    end else begin
      if (cmd_i.clr_res) begin
        res_adv_q <= 1'b0;
        res_q     <= '0;
      end
      if (cmd_i.tick) begin
        if (minute_inc >= epoch_min_q) begin
          minute_q  <= 8'd0;
          pending_q <= 1'b1;
        end else begin
          minute_q <= minute_inc;
        end
      end
      if (cmd_i.rpt_done) begin
        product_q <= md_q;
        heard_q   <= heard_q + 32'd1;
      end
      if (cmd_i.scan_init) begin
        scanning_q <= 1'b0;
        estimate_q <= heard_q;
      end
      if (cmd_i.set_reps) begin
        repeat_q   <= n_q;
        interval_q <= abrc_pkg::interval_for(n_q);
      end
      // Advert payload holds the values before the counters step.
      if (cmd_i.advert) begin
        res_adv_q                <= 1'b1;
        res_q.interval_units     <= interval_q;
        res_q.epoch_number       <= epoch_q;
        res_q.data_index         <= data_q;
        res_q.packet_index       <= packet_q;
        res_q.heard_estimate     <= estimate_q;
        res_q.repetitions        <= repeat_q;
        res_q.scan_start         <= (packet_inc >= repeat_q) && pending_q;
        if (packet_inc >= repeat_q) begin
          packet_q <= 4'd0;
          if (pending_q) begin
            pending_q        <= 1'b0;
            data_q           <= 32'd0;
            epoch_q          <= epoch_q + 16'd1;
            heard_q          <= 32'd0;
            product_q        <= abrc_pkg::PPM_ONE;
            scanning_q       <= 1'b1;
          end else begin
            data_q <= data_q + 32'd1;
          end
        end else begin
          packet_q <= packet_inc;
        end
      end
    end
  end

  // Output register: holds one word until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_adv_q <= res_adv_q;
      out_res_q <= res_q;
    end
  end

  assign st_o.action      = action_q;
  assign st_o.scanning    = scanning_q;
  assign st_o.md_done     = md_done;
  assign st_o.p_below     = p_q < target_q;
  assign st_o.n_below_max = n_q < 4'(MAX_REPEATS);
  assign st_o.out_free    = out_free;

  assign out_valid_o  = out_valid_q;
  assign out_advert_o = out_adv_q;
  assign out_res_o    = out_res_q;

  // The search count never passes the repetition limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_q >= 4'd1) && (n_q <= 4'(MAX_REPEATS)))
    else $error("repetition search count out of range");

  // Committed repetitions stay within the limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (repeat_q >= 4'd1) && (repeat_q <= 4'(MAX_REPEATS)))
    else $error("repetitions out of range");

  // A result is pushed only into a free output slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> out_free)
    else $error("result pushed over a waiting word");

endmodule

[design/abrc_ctrl.sv]
// ----------------------------------------------------------------------------
// Beacon repetition controller sequencer
// State machine that decodes each event and steps the datapath through it.
// ----------------------------------------------------------------------------
module abrc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  abrc_pkg::ctrl_status_t st_i,
  output abrc_pkg::ctrl_cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_DECODE    = 3'd1;
  localparam logic [2:0] ST_WAIT_RPT  = 3'd2;
  localparam logic [2:0] ST_WAIT_SCAN = 3'd3;
  localparam logic [2:0] ST_CHECK     = 3'd4;
  localparam logic [2:0] ST_WAIT_SQ   = 3'd5;
  localparam logic [2:0] ST_ADVERT    = 3'd6;
  localparam logic [2:0] ST_OUT       = 3'd7;

  logic [2:0] state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (st_i.action)
          abrc_pkg::ACT_ADVERT: begin
            if (st_i.scanning) begin
              cmd_o.clr_res = 1'b1;
            end else begin
              cmd_o.advert = 1'b1;
            end
            state_d = ST_OUT;
          end
          abrc_pkg::ACT_REPORT: begin
            cmd_o.clr_res = 1'b1;
            if (st_i.scanning) begin
              cmd_o.md_rpt = 1'b1;
              state_d      = ST_WAIT_RPT;
            end else begin
              state_d = ST_OUT;
            end
          end
          abrc_pkg::ACT_SCAN_END: begin
            if (st_i.scanning) begin
              cmd_o.md_scan   = 1'b1;
              cmd_o.scan_init = 1'b1;
              state_d         = ST_WAIT_SCAN;
            end else begin
              cmd_o.clr_res = 1'b1;
              state_d       = ST_OUT;
            end
          end
          default: begin
            cmd_o.tick    = 1'b1;
            cmd_o.clr_res = 1'b1;
            state_d       = ST_OUT;
          end
        endcase
      end
      ST_WAIT_RPT: begin
        if (st_i.md_done) begin
          cmd_o.rpt_done = 1'b1;
          state_d        = ST_OUT;
        end
      end
      ST_WAIT_SCAN: begin
        if (st_i.md_done) begin
          cmd_o.p_load = 1'b1;
          state_d      = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (st_i.p_below && st_i.n_below_max) begin
          cmd_o.md_sq = 1'b1;
          state_d     = ST_WAIT_SQ;
        end else begin
          cmd_o.set_reps = 1'b1;
          state_d        = ST_ADVERT;
        end
      end
      ST_WAIT_SQ: begin
        if (st_i.md_done) begin
          cmd_o.sq_done = 1'b1;
          state_d       = ST_CHECK;
        end
      end
      ST_ADVERT: begin
        cmd_o.advert = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        if (st_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == ST_IDLE;

  // A multiplier result arrives only while it is awaited.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_i.md_done |-> (state_q == ST_WAIT_RPT || state_q == ST_WAIT_SCAN ||
                      state_q == ST_WAIT_SQ))
    else $error("unexpected multiplier completion");

  // Every accepted word reaches the output stage before the next is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |=> state_q == ST_IDLE)
    else $error("sequencer did not return to idle after a push");

  // Advert emission follows a committed repetition count on scan end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADVERT) |-> $past(cmd_o.set_reps))
    else $error("scan-end advert without a repetition update");

endmodule

[design/adaptive_beacon_repetition_controller.sv]
// ----------------------------------------------------------------------------
// Adaptive beacon repetition controller
// Event-driven controller that paces a repeating beacon and adapts its
// repetition count from the reports heard during a scan window.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry an event kind on s_axis_tuser and a report length on
//   s_axis_tdata. Every accepted word yields exactly one output word;
//   m_axis_tuser is 1 when the word is an advert payload, and the payload
//   fields are zero otherwise. Configuration is written through
//   cfg_we_i/cfg_addr_i/cfg_data_i while no word is in work.
// Sequence:
//   Advert, tick and ignored events pass from decode straight to the output
//   stage; a heard report first waits for the shared scaled multiplier, and a
//   scan end waits for it once for the gateway loss and once per squaring step
//   of the repetition search, since each squaring step reuses the multiplier.
//   One word is in work at a time; the next is taken once the sequencer is
//   back in idle after the output register loads.
//   While a word waits in the output register and m_axis_tready is low,
//   the register holds it and the block waits in its last stage, so the input stalls as well.
// Reset:
//   Asynchronous, active low. Counters and configuration take their
//   defaults; the output register is empty.
// ----------------------------------------------------------------------------
module adaptive_beacon_repetition_controller #(
  parameter int MAX_REPEATS = 10
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [4:0] report_length
  input  logic [1:0]   s_axis_tuser,   // [1:0] action
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [10:0] interval_units, [26:11] epoch_number, [58:27] data_index,
  // [62:59] packet_index, [94:63] heard_estimate, [98:95] repetitions,
  // [99] scan_start
  output logic [103:0] m_axis_tdata,
  output logic         m_axis_tuser,   // [0] advert_valid
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [19:0]  cfg_data_i
);

  abrc_pkg::ctrl_cmd_t    cmd;
  abrc_pkg::ctrl_status_t st;
  abrc_pkg::result_t      res;

  abrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  abrc_datapath #(
    .MAX_REPEATS (MAX_REPEATS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .action_i        (s_axis_tuser),
    .report_length_i (s_axis_tdata[4:0]),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .st_o            (st),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .out_advert_o    (m_axis_tuser),
    .out_res_o       (res)
  );

  assign m_axis_tdata = {4'd0, res};

endmodule
